// ===== sv/svc_pkg.sv =====
// shared types and constants for the six channel variance calibrator
`default_nettype none
package svc_pkg;

  localparam int CHANNELS        = 6;
  localparam int CH_W            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RAW_W           = 16;
  localparam int CNT_W           = 16;
  localparam int VAR_W           = 40;
  localparam int M2_W            = 64;
  localparam int FRAC_SHIFT      = 24;
  localparam int DIV_W           = M2_W;
  localparam int STEP_W          = $clog2(DIV_W + 1);
  localparam int FIFO_DEPTH      = 2;
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 40;

  localparam logic [CNT_W-1:0]     TARGET_RESET = CNT_W'(1000);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VAR  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_DROP,
    KIND_RESTART
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } fq_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MEAN,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_M2,
    S_VLOAD,
    S_VDIV,
    S_VFIN,
    S_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/six_channel_variance_calibrator.sv =====
// top level of the six channel variance calibrator
// Usage: push sample sets or restart commands into the in_ queue while in_full is
// low; one result per item appears at the out_ queue, read with out_pop while
// out_empty is low. Registers are written on the cfg_ channel (cfg_ready is
// always high); the user must write them only while the block is idle; the block
// does not enforce it. Index 0: freeze target, 1: variance floor, others ignored.
// A restart, a dropped item or a sample set after the freeze goes straight to the
// result. A sample set runs the serial mean divider, shared by all six channels,
// once per channel. The set that reaches the target adds a 64-step variance
// division per channel, or only loads the floor when the count is below two.
// Throughput: one item at a time in the back end; a two-entry input queue and
// a result register let the sender and receiver stall on their own.
// Reset clears counter, means, M2, variances and the frozen flag and loads the
// default target of 1000 and a floor of zero.
// A stalled receiver holds the result; the back end then waits with the next
// finished item and the input queue fills and raises in_full.
`default_nettype none
module six_channel_variance_calibrator import svc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic                  in_opcode,
  input  wire logic                  in_sample_valid,
  input  wire logic [RAW_W-1:0]      in_accel_x,
  input  wire logic [RAW_W-1:0]      in_accel_y,
  input  wire logic [RAW_W-1:0]      in_accel_z,
  input  wire logic [RAW_W-1:0]      in_gyro_x,
  input  wire logic [RAW_W-1:0]      in_gyro_y,
  input  wire logic [RAW_W-1:0]      in_gyro_z,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_ready_res,
  output logic [CNT_W-1:0]           out_samples_taken,
  output logic [VAR_W-1:0]           out_accel_x_var,
  output logic [VAR_W-1:0]           out_accel_y_var,
  output logic [VAR_W-1:0]           out_accel_z_var,
  output logic [VAR_W-1:0]           out_gyro_x_var,
  output logic [VAR_W-1:0]           out_gyro_y_var,
  output logic [VAR_W-1:0]           out_gyro_z_var,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]                     target_r;
  logic [VAR_W-1:0]                     min_var_r;
  logic [CHANNELS-1:0][RAW_W-1:0]       raw;
  fq_ctl_t                              q_ctl;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] q_samples;
  logic                                 q_pop;
  logic                                 out_valid;
  logic                                 back_pop;
  logic [CHANNELS-1:0][VAR_W-1:0]       out_var;

  assign raw[0] = in_accel_x;
  assign raw[1] = in_accel_y;
  assign raw[2] = in_accel_z;
  assign raw[3] = in_gyro_x;
  assign raw[4] = in_gyro_y;
  assign raw[5] = in_gyro_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= TARGET_RESET;
      min_var_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET:  target_r  <= cfg_wdata[CNT_W-1:0];
        REG_MIN_VAR: min_var_r <= cfg_wdata[VAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  svc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_sample_valid (in_sample_valid),
    .raw             (raw),
    .q_ctl           (q_ctl),
    .q_samples       (q_samples),
    .q_pop           (q_pop)
  );

  assign back_pop = out_pop && out_valid;

  svc_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_ctl         (q_ctl),
    .q_samples     (q_samples),
    .q_pop         (q_pop),
    .target        (target_r),
    .min_var       (min_var_r),
    .out_valid     (out_valid),
    .out_pop       (back_pop),
    .out_ready_res (out_ready_res),
    .out_cnt       (out_samples_taken),
    .out_var       (out_var)
  );

  assign out_empty       = !out_valid;
  assign out_accel_x_var = out_var[0];
  assign out_accel_y_var = out_var[1];
  assign out_accel_z_var = out_var[2];
  assign out_gyro_x_var  = out_var[3];
  assign out_gyro_y_var  = out_var[4];
  assign out_gyro_z_var  = out_var[5];

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ctl.valid)
    else $error("back end took an item from an empty queue");

  a_zero_until_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_ready_res) |->
      (out_accel_x_var == '0) && (out_accel_y_var == '0) && (out_accel_z_var == '0) &&
      (out_gyro_x_var == '0) && (out_gyro_y_var == '0) && (out_gyro_z_var == '0))
    else $error("variance shown before freeze");

  a_pop_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty)
    else $error("finished item left no result");

endmodule
`default_nettype wire

// ===== sv/svc_front.sv =====
// input queue that classifies each item before the back end takes it
`default_nettype none
module svc_front import svc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_push,
  output logic                                       in_full,
  input  wire logic                                  in_opcode,
  input  wire logic                                  in_sample_valid,
  input  wire logic [CHANNELS-1:0][RAW_W-1:0]        raw,
  output fq_ctl_t                                    q_ctl,
  output logic      [CHANNELS-1:0][SAMPLE_BITS-1:0]  q_samples,
  input  wire logic                                  q_pop
);

  item_kind_t                                kind_r [FIFO_DEPTH];
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]      smp_r  [FIFO_DEPTH];
  logic                                      wr_r;
  logic                                      rd_r;
  logic [FIFO_CNT_W-1:0]                     cnt_r;
  logic                                      push_ok;
  logic                                      pop_ok;
  item_kind_t                                kind_in;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]      smp_in;
  logic [CHANNELS-1:0][SAMPLE_BITS+RAW_W-1:0] raw_ext;

  always_comb begin
    priority if (in_opcode) begin
      kind_in = KIND_RESTART;
    end else if (in_sample_valid) begin
      kind_in = KIND_SAMPLE;
    end else begin
      kind_in = KIND_DROP;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      raw_ext[i] = {SAMPLE_BITS'(0), raw[i]};
      smp_in[i]  = raw_ext[i][SAMPLE_BITS-1:0];
    end
  end

  assign in_full     = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign push_ok     = in_push && !in_full;
  assign pop_ok      = q_pop && (cnt_r != '0);
  assign q_ctl.valid = (cnt_r != '0);
  assign q_ctl.kind  = kind_r[rd_r];
  assign q_samples   = smp_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wr_r <= ~wr_r;
      end
      if (pop_ok) begin
        rd_r <= ~rd_r;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      kind_r[wr_r] <= kind_in;
      smp_r[wr_r]  <= smp_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/svc_back.sv =====
// sequencer with shared divider and multiplier for the welford update and freeze
`default_nettype none
module svc_back import svc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire fq_ctl_t                              q_ctl,
  input  wire logic [CHANNELS-1:0][SAMPLE_BITS-1:0] q_samples,
  output logic                                      q_pop,
  input  wire logic [CNT_W-1:0]                     target,
  input  wire logic [VAR_W-1:0]                     min_var,
  output logic                                      out_valid,
  input  wire logic                                 out_pop,
  output logic                                      out_ready_res,
  output logic [CNT_W-1:0]                          out_cnt,
  output logic [CHANNELS-1:0][VAR_W-1:0]            out_var
);

  localparam int MEAN_W = SAMPLE_BITS + 18;
  localparam int HL     = MEAN_W / 2;
  localparam int HH     = MEAN_W - HL;
  localparam int PW     = MEAN_W + HH;
  localparam int AW     = 2 * MEAN_W;
  localparam int SW     = AW - FRAC_SHIFT;

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic [CH_W-1:0]          ch_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     frozen_r;
  logic signed [MEAN_W-1:0] mean_r [CHANNELS];
  logic [M2_W-1:0]          m2_r   [CHANNELS];
  logic [VAR_W-1:0]         fvar_r [CHANNELS];

  logic [DIV_W-1:0]         dq_r;
  logic [CNT_W-1:0]         rem_r;
  logic [CNT_W-1:0]         dvs_r;
  logic [STEP_W-1:0]        step_r;
  logic                     neg_r;
  logic [MEAN_W-1:0]        mag_a_r;
  logic [MEAN_W-1:0]        mag_b_r;
  logic                     opp_r;
  logic [PW-1:0]            prod_r;
  logic [AW-1:0]            acc_r;

  logic                     ov_r;
  logic                     ordy_r;
  logic [CNT_W-1:0]         ocnt_r;
  logic [CHANNELS-1:0][VAR_W-1:0] ovar_r;

  logic [SAMPLE_BITS-1:0]   xs;
  logic signed [MEAN_W-1:0] xq;
  logic signed [MEAN_W-1:0] mean_cur;
  logic signed [MEAN_W-1:0] delta;
  logic [MEAN_W-1:0]        dmag;
  logic [MEAN_W-1:0]        quo;
  logic [MEAN_W-1:0]        qs;
  logic signed [MEAN_W-1:0] mean_new;
  logic signed [MEAN_W-1:0] d2;
  logic [MEAN_W-1:0]        d2mag;
  logic                     opp;
  logic [CNT_W:0]           t;
  logic                     ge;
  logic [CNT_W:0]           tsub;
  logic [HH-1:0]            mul_b;
  logic [PW-1:0]            mul_p;
  logic [AW-1:0]            acc_sum;
  logic [M2_W-1:0]          prod_s;
  logic [M2_W:0]            m2_sum;
  logic [M2_W-1:0]          m2_new;
  logic [CNT_W-1:0]         n_eff;
  logic [VAR_W-1:0]         vsat;
  logic [VAR_W-1:0]         vfin;
  logic                     last_ch;
  logic                     freeze_hit;
  logic                     small_n;
  logic                     out_take;

  always_comb begin
    xs       = q_samples[ch_r];
    xq       = {{2{xs[SAMPLE_BITS-1]}}, xs, 16'b0};
    mean_cur = mean_r[ch_r];
    delta    = xq - mean_cur;
    dmag     = delta[MEAN_W-1] ? (~delta + MEAN_W'(1)) : delta;
    quo      = dq_r[MEAN_W-1:0];
    qs       = neg_r ? (~quo + MEAN_W'(1)) : quo;
    mean_new = mean_cur + $signed(qs);
    d2       = xq - mean_new;
    d2mag    = d2[MEAN_W-1] ? (~d2 + MEAN_W'(1)) : d2;
    opp      = (delta[MEAN_W-1] && !d2[MEAN_W-1] && (d2 != '0)) ||
               (!delta[MEAN_W-1] && (delta != '0) && d2[MEAN_W-1]);
    t        = {rem_r, dq_r[DIV_W-1]};
    ge       = (t >= {1'b0, dvs_r});
    tsub     = t - {1'b0, dvs_r};
    mul_b    = (state_r == S_MUL_LO) ? HH'(mag_b_r[HL-1:0]) : mag_b_r[MEAN_W-1:HL];
    mul_p    = {HH'(0), mag_a_r} * {MEAN_W'(0), mul_b};
    acc_sum  = acc_r + {prod_r, HL'(0)};
    prod_s   = opp_r ? '0 : {(M2_W-SW)'(0), acc_r[AW-1:FRAC_SHIFT]};
    m2_sum   = {1'b0, m2_r[ch_r]} + {1'b0, prod_s};
    m2_new   = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
    n_eff    = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
    vsat     = (|dq_r[DIV_W-1:VAR_W]) ? '1 : dq_r[VAR_W-1:0];
    vfin     = (vsat > min_var) ? vsat : min_var;
    last_ch    = (ch_r == CH_W'(CHANNELS - 1));
    freeze_hit = (target <= cnt_r);
    small_n    = (cnt_r < CNT_W'(2));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_ctl.valid) begin
          state_nxt = (q_ctl.kind == KIND_SAMPLE && !frozen_r) ? S_LOAD : S_OUT;
        end
      end
      S_LOAD:   state_nxt = S_DIV;
      S_DIV:    state_nxt = (step_r == STEP_W'(1)) ? S_MEAN : S_DIV;
      S_MEAN:   state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_ACC;
      S_ACC:    state_nxt = S_M2;
      S_M2: begin
        if (last_ch) begin
          state_nxt = freeze_hit ? S_VLOAD : S_OUT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_VLOAD: begin
        if (small_n) begin
          state_nxt = last_ch ? S_OUT : S_VLOAD;
        end else begin
          state_nxt = S_VDIV;
        end
      end
      S_VDIV:   state_nxt = (step_r == STEP_W'(1)) ? S_VFIN : S_VDIV;
      S_VFIN:   state_nxt = last_ch ? S_OUT : S_VLOAD;
      S_OUT:    state_nxt = out_take ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_take = (state_r == S_OUT) && (!ov_r || out_pop);
    q_pop    = out_take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ch_r     <= '0;
      cnt_r    <= '0;
      frozen_r <= 1'b0;
      ov_r     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        mean_r[i] <= '0;
        m2_r[i]   <= '0;
        fvar_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= out_take || (ov_r && !out_pop);
      unique case (state_r)
        S_IDLE: begin
          if (q_ctl.valid) begin
            ch_r <= '0;
            unique case (q_ctl.kind)
              KIND_RESTART: begin
                cnt_r    <= '0;
                frozen_r <= 1'b0;
                for (int i = 0; i < CHANNELS; i++) begin
                  mean_r[i] <= '0;
                  m2_r[i]   <= '0;
                  fvar_r[i] <= '0;
                end
              end
              KIND_SAMPLE: begin
                if (!frozen_r) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MEAN: mean_r[ch_r] <= mean_new;
        S_M2: begin
          m2_r[ch_r] <= m2_new;
          if (last_ch) begin
            ch_r <= '0;
            if (freeze_hit) begin
              frozen_r <= 1'b1;
            end
          end else begin
            ch_r <= ch_r + CH_W'(1);
          end
        end
        S_VLOAD: begin
          if (small_n) begin
            fvar_r[ch_r] <= min_var;
            if (!last_ch) begin
              ch_r <= ch_r + CH_W'(1);
            end
          end
        end
        S_VFIN: begin
          fvar_r[ch_r] <= vfin;
          if (!last_ch) begin
            ch_r <= ch_r + CH_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        dq_r   <= {dmag, (DIV_W-MEAN_W)'(0)};
        rem_r  <= '0;
        dvs_r  <= n_eff;
        step_r <= STEP_W'(MEAN_W);
        neg_r  <= delta[MEAN_W-1];
      end
      S_DIV, S_VDIV: begin
        dq_r   <= {dq_r[DIV_W-2:0], ge};
        rem_r  <= ge ? tsub[CNT_W-1:0] : t[CNT_W-1:0];
        step_r <= step_r - STEP_W'(1);
      end
      S_MEAN: begin
        mag_a_r <= dmag;
        mag_b_r <= d2mag;
        opp_r   <= opp;
      end
      S_MUL_LO: prod_r <= mul_p;
      S_MUL_HI: begin
        acc_r  <= {HL'(0), prod_r};
        prod_r <= mul_p;
      end
      S_ACC: acc_r <= acc_sum;
      S_VLOAD: begin
        dq_r   <= m2_r[ch_r];
        rem_r  <= '0;
        dvs_r  <= cnt_r - CNT_W'(1);
        step_r <= STEP_W'(DIV_W);
      end
      S_OUT: begin
        if (out_take) begin
          ordy_r <= frozen_r;
          ocnt_r <= cnt_r;
          for (int i = 0; i < CHANNELS; i++) begin
            ovar_r[i] <= fvar_r[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid     = ov_r;
  assign out_ready_res = ordy_r;
  assign out_cnt       = ocnt_r;
  assign out_var       = ovar_r;

endmodule
`default_nettype wire
